@@ hw/rtl/abaf_pkg.sv @@
package abaf_pkg;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;
	localparam logic [1:0] REG_THRESHOLD    = 2'd3;

	localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
	localparam logic [3:0]  RST_WINDOW_SIZE  = 4'd5;
	localparam logic [16:0] RST_THRESHOLD    = 17'd15360;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [3:0] CMD_NONE   = 4'd0;
	localparam logic [3:0] CMD_ACCEPT = 4'd1;
	localparam logic [3:0] CMD_SUM    = 4'd2;
	localparam logic [3:0] CMD_MUL1   = 4'd3;
	localparam logic [3:0] CMD_MUL2   = 4'd4;
	localparam logic [3:0] CMD_MUL3   = 4'd5;
	localparam logic [3:0] CMD_CMP    = 4'd6;
	localparam logic [3:0] CMD_DIV    = 4'd7;
	localparam logic [3:0] CMD_EMIT   = 4'd8;

	typedef struct packed {
		logic [3:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic step_ready;
		logic sum_done;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

@@ hw/rtl/abaf_ram.sv @@
module abaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/abaf_ctrl.sv @@
module abaf_ctrl import abaf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_STEP = 4'd1;
	localparam logic [3:0] ST_SUM  = 4'd2;
	localparam logic [3:0] ST_MUL1 = 4'd3;
	localparam logic [3:0] ST_MUL2 = 4'd4;
	localparam logic [3:0] ST_MUL3 = 4'd5;
	localparam logic [3:0] ST_CMP  = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.code = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.code = CMD_ACCEPT;
					state_d  = ST_STEP;
				end
			end
			ST_STEP: begin
				if (status.step_ready) begin
					cmd.code = CMD_SUM;
					state_d  = ST_SUM;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SUM: begin
				if (status.sum_done) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.code = CMD_MUL1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.code = CMD_MUL2;
				state_d  = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.code = CMD_MUL3;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				cmd.code = CMD_CMP;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_EMIT;
				end else begin
					cmd.code = CMD_DIV;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.code = CMD_EMIT;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/abaf_dp.sv @@
module abaf_dp import abaf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wr_data,
	input  logic        in_command,
	input  logic [7:0]  in_pixel,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_value,
	output logic        out_small,
	output logic        out_last
);

	localparam int STORE_ROWS = MAX_WINDOW + 2;
	localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
	localparam int MOD_W      = $clog2(STORE_ROWS);
	localparam int MS_W       = $clog2(STORE_ROWS + MAX_WINDOW) + 1;
	localparam int K_W        = $clog2(MAX_WINDOW + 1);
	localparam int N_W        = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
	localparam int SK_W       = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
	localparam int S3_W       = 12;
	localparam int NUM_W      = SK_W + 8;
	localparam int P_W        = (S3_W + N_W > SK_W + 4) ? S3_W + N_W : SK_W + 4;
	localparam int D_W        = P_W + 1;
	localparam int N9_W       = N_W + 4;
	localparam int T_W        = 17 + N9_W + 1;
	localparam int CMP_W      = ((P_W + 9 > T_W) ? P_W + 9 : T_W) + 1;
	localparam int DCNT_W     = $clog2(NUM_W + 1);

	function automatic logic [MOD_W-1:0] mod_inc(input logic [MOD_W-1:0] m);
		logic [MOD_W-1:0] r;
		if (m == MOD_W'(STORE_ROWS - 1)) begin
			r = '0;
		end else begin
			r = m + MOD_W'(1);
		end
		return r;
	endfunction

	logic [10:0] cfg_w_q;
	logic [10:0] cfg_h_q;
	logic [3:0]  cfg_k_q;
	logic [16:0] cfg_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q   <= RST_IMAGE_WIDTH;
			cfg_h_q   <= RST_IMAGE_HEIGHT;
			cfg_k_q   <= RST_WINDOW_SIZE;
			cfg_thr_q <= RST_THRESHOLD;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_w_q   <= cfg_wr_data[10:0];
				REG_IMAGE_HEIGHT: cfg_h_q   <= cfg_wr_data[10:0];
				REG_WINDOW_SIZE:  cfg_k_q   <= cfg_wr_data[3:0];
				REG_THRESHOLD:    cfg_thr_q <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	logic [COL_W-1:0] w;
	logic [ROW_W-1:0] h;
	logic [K_W-1:0]   k;
	logic [K_W-1:0]   la_raw;
	logic [K_W-1:0]   la;

	always_comb begin
		if (cfg_w_q == '0) begin
			w = COL_W'(1);
		end else if (32'(cfg_w_q) > MAX_WIDTH) begin
			w = COL_W'(MAX_WIDTH);
		end else begin
			w = COL_W'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			h = ROW_W'(1);
		end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
			h = ROW_W'(MAX_HEIGHT);
		end else begin
			h = ROW_W'(cfg_h_q);
		end
		if (cfg_k_q == '0) begin
			k = K_W'(1);
		end else if (32'(cfg_k_q) > MAX_WINDOW) begin
			k = K_W'(MAX_WINDOW);
		end else begin
			k = K_W'(cfg_k_q);
		end
		la_raw = k - K_W'(1) - (k >> 1);
		la     = (la_raw == '0) ? K_W'(1) : la_raw;
	end

	logic [COL_W-1:0] ic_q, oc_q;
	logic [ROW_W-1:0] ir_q, or_q;
	logic [MOD_W-1:0] irm_q, orm_q;
	logic             ready_q;

	logic [COL_W-1:0] ic_a, oc_a, ic_b;
	logic [ROW_W:0]   ir_a, or_a, ir_b;
	logic [MOD_W-1:0] irm_a, orm_a, irm_b;
	logic [ROW_W:0]   nr;
	logic [COL_W:0]   nc;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic             step_ready;
	logic             accept;
	logic             emit;

	assign accept = (cmd.code == CMD_ACCEPT);
	assign emit   = (cmd.code == CMD_EMIT);

	always_comb begin
		ic_a  = ic_q;
		ir_a  = {1'b0, ir_q};
		irm_a = irm_q;
		oc_a  = oc_q;
		or_a  = {1'b0, or_q};
		orm_a = orm_q;
		if (ic_q >= w) begin
			ic_a  = '0;
			ir_a  = ir_a + (ROW_W + 1)'(1);
			irm_a = mod_inc(irm_q);
		end
		if (ir_a >= {1'b0, h}) begin
			ir_a = {1'b0, h};
			ic_a = '0;
		end
		if (oc_q >= w) begin
			oc_a  = '0;
			or_a  = or_a + (ROW_W + 1)'(1);
			orm_a = mod_inc(orm_q);
		end
		if (or_a >= {1'b0, h}) begin
			ic_a  = '0;
			ir_a  = '0;
			irm_a = '0;
			oc_a  = '0;
			or_a  = '0;
			orm_a = '0;
		end
		wr_en   = accept && (in_command == OP_PIXEL) && (ir_a < {1'b0, h});
		wr_addr = ADDR_W'(32'(irm_a) * MAX_WIDTH + 32'(ic_a));
		ic_b  = ic_a;
		ir_b  = ir_a;
		irm_b = irm_a;
		if (wr_en) begin
			ic_b = ic_a + COL_W'(1);
			if (ic_b >= w) begin
				ic_b  = '0;
				ir_b  = ir_a + (ROW_W + 1)'(1);
				irm_b = mod_inc(irm_a);
			end
		end
		nr = or_a + (ROW_W + 1)'(la);
		if (nr > {1'b0, h - ROW_W'(1)}) begin
			nr = {1'b0, h - ROW_W'(1)};
		end
		nc = {1'b0, oc_a} + (COL_W + 1)'(la);
		if (nc > {1'b0, w - COL_W'(1)}) begin
			nc = {1'b0, w - COL_W'(1)};
		end
		step_ready = (ir_b >= {1'b0, h}) || (ir_b > nr) ||
			((ir_b == nr) && ({1'b0, ic_b} > nc));
	end

	logic out_last_d;
	logic [COL_W-1:0] oc_inc;

	assign out_last_d = (or_q == h - ROW_W'(1)) && (oc_q == w - COL_W'(1));
	assign oc_inc     = oc_q + COL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q    <= '0;
			ir_q    <= '0;
			irm_q   <= '0;
			oc_q    <= '0;
			or_q    <= '0;
			orm_q   <= '0;
			ready_q <= 1'b0;
		end else if (accept) begin
			ic_q    <= ic_b;
			ir_q    <= ROW_W'(ir_b);
			irm_q   <= irm_b;
			oc_q    <= oc_a;
			or_q    <= ROW_W'(or_a);
			orm_q   <= orm_a;
			ready_q <= step_ready;
		end else if (emit) begin
			if (out_last_d) begin
				ic_q  <= '0;
				ir_q  <= '0;
				irm_q <= '0;
				oc_q  <= '0;
				or_q  <= '0;
				orm_q <= '0;
			end else if (oc_inc >= w) begin
				oc_q  <= '0;
				or_q  <= or_q + ROW_W'(1);
				orm_q <= mod_inc(orm_q);
			end else begin
				oc_q <= oc_inc;
			end
		end
	end

	logic [K_W-1:0]   i_q, j_q;
	logic             pass_q;
	logic             issue_q;
	logic             vld_s1;
	logic             oob_s1;
	logic             pass_s1;
	logic [S3_W-1:0]  s3_q;
	logic [SK_W-1:0]  sk_q;

	logic [K_W-1:0]    kk, top;
	logic [ROW_W+1:0]  r_off, rr;
	logic [COL_W+1:0]  c_off, cc;
	logic [MS_W-1:0]   tm;
	logic [MOD_W-1:0]  rmod;
	logic              oob;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	always_comb begin
		kk    = pass_q ? k : K_W'(3);
		top   = kk >> 1;
		r_off = (ROW_W + 2)'(or_q) + (ROW_W + 2)'(i_q);
		c_off = (COL_W + 2)'(oc_q) + (COL_W + 2)'(j_q);
		rr    = r_off - (ROW_W + 2)'(top);
		cc    = c_off - (COL_W + 2)'(top);
		oob   = !((r_off >= (ROW_W + 2)'(top)) && (rr < (ROW_W + 2)'(h)) &&
			(c_off >= (COL_W + 2)'(top)) && (cc < (COL_W + 2)'(w)));
		tm = MS_W'(orm_q) + MS_W'(i_q);
		if (tm < MS_W'(top)) begin
			tm = tm + MS_W'(STORE_ROWS) - MS_W'(top);
		end else begin
			tm = tm - MS_W'(top);
		end
		if (tm >= MS_W'(STORE_ROWS)) begin
			tm = tm - MS_W'(STORE_ROWS);
		end
		rmod    = MOD_W'(tm);
		rd_addr = ADDR_W'(32'(rmod) * MAX_WIDTH + 32'(cc));
	end

	abaf_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (in_pixel),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			pass_q  <= 1'b0;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			if (cmd.code == CMD_SUM) begin
				i_q     <= '0;
				j_q     <= '0;
				pass_q  <= 1'b0;
				issue_q <= 1'b1;
			end else if (issue_q) begin
				if (j_q == kk - K_W'(1)) begin
					j_q <= '0;
					if (i_q == kk - K_W'(1)) begin
						i_q <= '0;
						if (pass_q) begin
							issue_q <= 1'b0;
						end else begin
							pass_q <= 1'b1;
						end
					end else begin
						i_q <= i_q + K_W'(1);
					end
				end else begin
					j_q <= j_q + K_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		oob_s1  <= oob;
		pass_s1 <= pass_q;
		if (cmd.code == CMD_SUM) begin
			s3_q <= '0;
			sk_q <= '0;
		end else if (vld_s1) begin
			if (pass_s1) begin
				sk_q <= sk_q + (oob_s1 ? SK_W'(1) : SK_W'(rd_data));
			end else begin
				s3_q <= s3_q + (oob_s1 ? S3_W'(1) : S3_W'(rd_data));
			end
		end
	end

	logic [N_W-1:0]    n_q;
	logic [P_W-1:0]    p1_q, p2_q;
	logic [N9_W-1:0]   n9_q;
	logic [P_W-1:0]    ad_q;
	logic signed [T_W-1:0] tn_q;
	logic              small_q;
	logic signed [D_W-1:0] diff;
	logic              small_d;
	logic [NUM_W-1:0]  num_q;
	logic [N_W-1:0]    dvs_q;
	logic [N_W-1:0]    rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [N_W:0]      rem_sh;
	logic [N_W:0]      trial;

	always_comb begin
		diff    = $signed({1'b0, p1_q}) - $signed({1'b0, p2_q});
		small_d = $signed({{(CMP_W - P_W - 8){1'b0}}, ad_q, 8'b0}) >
			$signed({{(CMP_W - T_W){tn_q[T_W-1]}}, tn_q});
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		trial   = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_MUL1: begin
				n_q <= N_W'(k * k);
			end
			CMD_MUL2: begin
				p1_q <= P_W'(s3_q * n_q);
				p2_q <= P_W'(sk_q * 4'd9);
				n9_q <= N9_W'(n_q * 4'd9);
			end
			CMD_MUL3: begin
				ad_q <= diff[D_W-1] ? P_W'(-diff) : P_W'(diff);
				tn_q <= T_W'($signed(cfg_thr_q) * $signed({1'b0, n9_q}));
			end
			CMD_CMP: begin
				small_q <= small_d;
				rem_q   <= '0;
				if (small_d) begin
					num_q <= NUM_W'({s3_q, 8'b0}) + NUM_W'(4);
					dvs_q <= N_W'(9);
				end else begin
					num_q <= NUM_W'({sk_q, 8'b0}) + NUM_W'(n_q >> 1);
					dvs_q <= n_q;
				end
			end
			CMD_DIV: begin
				if (!trial[N_W]) begin
					rem_q <= N_W'(trial);
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= N_W'(rem_sh);
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.code == CMD_CMP) begin
			dcnt_q <= DCNT_W'(NUM_W);
		end else if (cmd.code == CMD_DIV && dcnt_q != '0) begin
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	logic outv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
		end else if (emit) begin
			outv_q <= 1'b1;
		end else if (out_ready) begin
			outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value <= num_q[15:0];
			out_small <= small_q;
			out_last  <= out_last_d;
		end
	end

	assign out_valid         = outv_q;
	assign status.step_ready = ready_q;
	assign status.sum_done   = !issue_q && !vld_s1;
	assign status.div_done   = (dcnt_q == '0);
	assign status.out_free   = !outv_q || out_ready;

	a_no_write_during_sum: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> !wr_en)
		else $error("line store written while a window is being read");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == CMD_EMIT) |=> outv_q)
		else $error("result not presented after emit");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == CMD_EMIT) |-> (!outv_q || out_ready))
		else $error("result overwritten before transfer");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(dcnt_q) <= NUM_W)
		else $error("divider step count out of range");

endmodule

@@ hw/rtl/adaptive_box_average_filter.sv @@
// Edge-preserving box average filter for 8-bit raster pixels. Each accepted item
// (pixel or drain) reads both windows from the line store, one pixel per cycle
// through its single read port, then runs the three multiply steps, the compare
// and a bit-serial divider of MAX_WINDOW-derived width (24 steps at the default);
// an item that produces no result returns to idle after the readiness check. A
// finished result waits in the output register while the next item is taken.
// The line store needs no clearing after reset.
module adaptive_box_average_filter import abaf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // pixel
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // filtered_value
	output logic        m_tuser,   // used_small_window
	output logic        m_tlast
);

	dp_cmd_t    cmd;
	dp_status_t status;

	abaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	abaf_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_command  (s_tuser),
		.in_pixel    (s_tdata),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_value   (m_tdata),
		.out_small   (m_tuser),
		.out_last    (m_tlast)
	);

endmodule

@@ test/adaptive_box_average_filter_check.sv @@
`timescale 1ns / 100ps

module adaptive_box_average_filter_check import abaf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	input  logic        end_check,
	output int          failures
);

	localparam int MAX_W      = 1024;
	localparam int MAX_H      = 1024;
	localparam int MAX_K      = 15;
	localparam int STORE_ROWS = MAX_K + 2;

	typedef struct packed {
		logic [15:0] average;
		logic        small_win;
		logic        frame_end;
	} filtered_t;

	logic [7:0]  pixel_rows [STORE_ROWS * MAX_W];
	logic [10:0] width_reg;
	logic [10:0] height_reg;
	logic [3:0]  window_reg;
	logic [16:0] threshold_reg;
	int          in_col, in_row, out_col, out_row;
	filtered_t   pending_averages [$];
	bit          leftover_flagged;

	function automatic int clamp_to(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int box_sum(int orow, int ocol, int side, int w, int h);
		int top;
		int r;
		int c;
		int sum;
		top = side / 2;
		sum = 0;
		for (int i = 0; i < side; i++) begin
			r = orow + i - top;
			for (int j = 0; j < side; j++) begin
				c = ocol + j - top;
				if (r < 0 || r >= h || c < 0 || c >= w)
					sum += 1;
				else
					sum += pixel_rows[(r % STORE_ROWS) * MAX_W + (c % MAX_W)];
			end
		end
		return sum;
	endfunction

	task automatic filter_transfer(input logic cmd, input logic [7:0] pix);
		int        w, h, side, look, nr, nc, area, s3, sk;
		longint    thr, diff;
		bit        ready, use_small;
		int        avg;
		filtered_t res;
		w    = clamp_to(width_reg, MAX_W);
		h    = clamp_to(height_reg, MAX_H);
		side = clamp_to(window_reg, MAX_K);
		look = side - 1 - side / 2;
		if (look < 1) look = 1;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (in_row >= h) begin
			in_row = h;
			in_col = 0;
		end
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		if (out_row >= h) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end
		if (cmd == OP_PIXEL && in_row < h) begin
			pixel_rows[(in_row % STORE_ROWS) * MAX_W + (in_col % MAX_W)] = pix;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		nr = out_row + look;
		nc = out_col + look;
		if (nr > h - 1) nr = h - 1;
		if (nc > w - 1) nc = w - 1;
		ready = in_row >= h || in_row > nr || (in_row == nr && in_col > nc);
		if (!ready) return;
		area = side * side;
		s3   = box_sum(out_row, out_col, 3, w, h);
		sk   = box_sum(out_row, out_col, side, w, h);
		thr  = longint'(signed'(threshold_reg));
		diff = longint'(s3) * area - longint'(sk) * 9;
		if (diff < 0) diff = -diff;
		use_small     = diff * 256 > thr * 9 * area;
		avg           = use_small ? (s3 * 256 + 4) / 9 : (sk * 256 + area / 2) / area;
		res.average   = avg[15:0];
		res.small_win = use_small;
		res.frame_end = out_row == h - 1 && out_col == w - 1;
		pending_averages.push_back(res);
		if (res.frame_end) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		filtered_t want;
		if (!arst_n) begin
			width_reg     = RST_IMAGE_WIDTH;
			height_reg    = RST_IMAGE_HEIGHT;
			window_reg    = RST_WINDOW_SIZE;
			threshold_reg = RST_THRESHOLD;
			in_col        = 0;
			in_row        = 0;
			out_col       = 0;
			out_row       = 0;
			failures      = 0;
			pending_averages.delete();
			leftover_flagged = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_averages.size() == 0) begin
					$error("Output transfer with no result expected: value %h", m_tdata);
					failures++;
				end else begin
					want = pending_averages.pop_front();
					if (m_tdata !== want.average) begin
						$error("filtered_value: expected %h, actual %h", want.average, m_tdata);
						failures++;
					end
					if (m_tuser !== want.small_win) begin
						$error("used_small_window: expected %b, actual %b", want.small_win,
							m_tuser);
						failures++;
					end
					if (m_tlast !== want.frame_end) begin
						$error("last_of_frame: expected %b, actual %b", want.frame_end, m_tlast);
						failures++;
					end
				end
			end
			if (s_tvalid && s_tready)
				filter_transfer(s_tuser, s_tdata);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_reg = cfg_wr_data[10:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_wr_data[10:0];
					REG_WINDOW_SIZE:  window_reg = cfg_wr_data[3:0];
					REG_THRESHOLD:    threshold_reg = cfg_wr_data;
					default: ;
				endcase
			end
			if (end_check && !leftover_flagged && pending_averages.size() != 0) begin
				$error("%0d expected results never arrived", pending_averages.size());
				failures++;
				leftover_flagged = 1;
			end
		end
	end

endmodule

@@ test/adaptive_box_average_filter_test.sv @@
`timescale 1ns / 100ps

module adaptive_box_average_filter_test;
	import abaf_pkg::*;

	localparam longint CYCLE_LIMIT = 6000000;
	localparam int     SETTLE      = 400;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic [1:0]  cfg_index = REG_IMAGE_WIDTH;
	logic [16:0] cfg_wr_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = OP_PIXEL;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        end_check = 0;
	int          failures;

	longint cycles = 0;
	bit     quiet = 0;
	int     stall_left = 0;
	int     items_sent = 0;
	int     results_seen = 0;
	int     frame_results = 0;
	bit     frame_closed = 0;
	int     frames_run = 0;

	adaptive_box_average_filter i_dut (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

	adaptive_box_average_filter_check i_check (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.end_check, .failures
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen++;
			frame_results++;
			if (m_tlast)
				frame_closed = 1;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 0;
		end else if (quiet || $urandom_range(0, 9) < 7) begin
			m_tready <= 1;
		end else begin
			stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
			m_tready <= 0;
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 15);
		if (r < 10) return 0;
		if (r < 15) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(input logic cmd, input logic [7:0] pix);
		int  gap;
		bit  taken;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= cmd;
		s_tdata  <= pix;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	task automatic write_settings(input int w, input int h, input int k, input int thr);
		logic [16:0] vals [4];
		vals[REG_IMAGE_WIDTH]  = 17'(w);
		vals[REG_IMAGE_HEIGHT] = 17'(h);
		vals[REG_WINDOW_SIZE]  = 17'(k);
		vals[REG_THRESHOLD]    = 17'(thr);
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en   <= 1;
			cfg_index   <= 2'(i);
			cfg_wr_data <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	// The frame ends on the tlast transfer; pixels sent while outputs are still pending
	// are dropped, so they go only where several outputs are surely still to come.
	task automatic run_frame(input int w, input int h, input int k, input int thr);
		int ew, eh, total;
		ew = (w[10:0] < 1) ? 1 : (w[10:0] > 1024 ? 1024 : w[10:0]);
		eh = (h[10:0] < 1) ? 1 : (h[10:0] > 1024 ? 1024 : h[10:0]);
		total = ew * eh;
		write_settings(w, h, k, thr);
		frame_results = 0;
		frame_closed  = 0;
		quiet = $urandom_range(0, 3) == 0;
		for (int p = 0; p < total; p++) begin
			if ($urandom_range(0, 7) == 0)
				send_item(OP_DRAIN, pick_pixel());
			send_item(OP_PIXEL, pick_pixel());
		end
		while (!frame_closed) begin
			if (frame_results + 4 < total && $urandom_range(0, 3) == 0)
				send_item(OP_PIXEL, pick_pixel());
			else
				send_item(OP_DRAIN, pick_pixel());
		end
		s_tvalid <= 0;
		repeat (SETTLE) @(posedge clk);
		frames_run++;
	endtask

	initial begin
		int w, h, k, thr;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		run_frame(4, 3, 15, 17'h1FF00);
		run_frame(5, 2, 1, 65535);
		run_frame(0, 0, 0, 0);
		run_frame(3, 4, 2, 256);
		run_frame(2047, 1, 1, 0);

		while (items_sent < 1300) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			h = $urandom_range(1, 10);
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 6);
			case ($urandom_range(0, 5))
				0: thr = 17'h1FF00;
				1: thr = 65535;
				2: thr = $urandom_range(0, 17'h1FFFF);
				default: thr = $urandom_range(0, 4000);
			endcase
			run_frame(w, h, k, thr);
		end

		end_check <= 1;
		repeat (2) @(posedge clk);
		$display("Ran %0d frames with %0d input transfers and %0d output transfers,",
			frames_run, items_sent, results_seen);
		$display("sweeping frame size, window side and threshold including the extremes.");
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/abaf_pkg.sv
hw/rtl/abaf_ram.sv
hw/rtl/abaf_ctrl.sv
hw/rtl/abaf_dp.sv
hw/rtl/adaptive_box_average_filter.sv
test/adaptive_box_average_filter_check.sv
test/adaptive_box_average_filter_test.sv
